// File: rtl/core/mul_div_register_unit_core_defines.svh
// Assertion macros shared by the multiply/divide unit
`ifndef MUL_DIV_REGISTER_UNIT_CORE_DEFINES_SVH
`define MUL_DIV_REGISTER_UNIT_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MDRU_ASSERT_SAME(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MDRU_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/mdru_pkg.sv
package mdru_pkg;

    // register window offsets
    localparam logic [4:0] OFS_MUL_A      = 5'h02;
    localparam logic [4:0] OFS_MUL_B      = 5'h03;
    localparam logic [4:0] OFS_DIVIDEND_L = 5'h04;
    localparam logic [4:0] OFS_DIVIDEND_H = 5'h05;
    localparam logic [4:0] OFS_DIVISOR    = 5'h06;
    localparam logic [4:0] OFS_QUOT_L     = 5'h14;
    localparam logic [4:0] OFS_QUOT_H     = 5'h15;
    localparam logic [4:0] OFS_PR_L       = 5'h16;
    localparam logic [4:0] OFS_PR_H       = 5'h17;

    // access kinds
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // divide-by-zero quotient
    localparam logic [15:0] QUOT_DIV_ZERO = 16'hFFFF;

    // one quotient bit per step
    localparam int DIV_STEPS = 16;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_DIV
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;    // input transfer this cycle
        logic div_step;  // one restoring divide iteration
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_start; // current input is a write of a nonzero divisor
    } t_dp_status;

endpackage

// File: rtl/core/mdru_datapath.sv
module mdru_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mdru_pkg::t_dp_cmd   i_cmd,
    output mdru_pkg::t_dp_status o_status,
    input  logic                i_kind,
    input  logic [4:0]          i_register_offset,
    input  logic [7:0]          i_write_data,
    output logic [7:0]          o_read_data
);
    import mdru_pkg::*;

    logic [7:0]  r_mul_a;
    logic [15:0] r_dividend;
    logic [7:0]  r_divisor;
    logic [15:0] r_quotient;
    logic [15:0] r_prod_rem;
    logic [7:0]  r_rem;
    logic [7:0]  r_read_data;

    logic [7:0]  n_read_data;
    logic [8:0]  div_trial;
    logic        div_fits;
    logic [7:0]  n_rem;
    logic        is_write;

    assign is_write = (i_kind == KIND_WRITE);
    assign o_status.div_start = is_write && (i_register_offset == OFS_DIVISOR)
                                && (i_write_data != 8'd0);

    // restoring divide: shift the next dividend bit into the partial remainder
    assign div_trial = {r_rem, r_quotient[15]};
    assign div_fits  = (div_trial >= {1'b0, r_divisor});
    assign n_rem     = div_fits ? 8'(div_trial - {1'b0, r_divisor}) : div_trial[7:0];

    // read mux; writes return zero
    always_comb begin
        n_read_data = 8'd0;
        if (!is_write) begin
            case (i_register_offset)
                OFS_QUOT_L: n_read_data = r_quotient[7:0];
                OFS_QUOT_H: n_read_data = r_quotient[15:8];
                OFS_PR_L:   n_read_data = r_prod_rem[7:0];
                OFS_PR_H:   n_read_data = r_prod_rem[15:8];
                default:    n_read_data = 8'd0;
            endcase
        end
    end

    // architectural registers and divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_a    <= '0;
            r_dividend <= '0;
            r_divisor  <= '0;
            r_quotient <= '0;
            r_prod_rem <= '0;
            r_rem      <= '0;
        end else if (i_cmd.div_step) begin
            r_quotient <= {r_quotient[14:0], div_fits};
            r_rem      <= n_rem;
            r_prod_rem <= {8'd0, n_rem};
        end else if (i_cmd.accept && is_write) begin
            case (i_register_offset)
                OFS_MUL_A: r_mul_a <= i_write_data;
                OFS_MUL_B: begin
                    // multiplier is consumed at once, only the product is kept
                    r_prod_rem <= {8'd0, r_mul_a} * {8'd0, i_write_data};
                end
                OFS_DIVIDEND_L: r_dividend[7:0]  <= i_write_data;
                OFS_DIVIDEND_H: r_dividend[15:8] <= i_write_data;
                OFS_DIVISOR: begin
                    r_divisor <= i_write_data;
                    r_rem     <= '0;
                    if (i_write_data == 8'd0) begin
                        r_quotient <= QUOT_DIV_ZERO;
                        r_prod_rem <= r_dividend;
                    end else begin
                        // quotient register doubles as the dividend shifter
                        r_quotient <= r_dividend;
                    end
                end
                default: ;
            endcase
        end
    end

    // output data register
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_read_data <= n_read_data;
        end
    end

    assign o_read_data = r_read_data;

endmodule

// File: rtl/core/mdru_ctrl.sv
module mdru_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    output logic                 o_valid,
    input  logic                 i_ready,
    input  mdru_pkg::t_dp_status i_status,
    output mdru_pkg::t_dp_cmd    o_cmd
);
    import mdru_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;
    logic              r_out_valid;
    logic              n_out_valid;
    logic              accept;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    // input ready only when idle and the result slot is free or draining
    assign o_ready = (r_state == ST_IDLE) && (!r_out_valid || i_ready);
    assign accept  = i_valid && o_ready;

    // next state and commands
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        o_cmd.accept   = 1'b0;
        o_cmd.div_step = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.accept = accept;
                if (accept && i_status.div_start) begin
                    n_state = ST_DIV;
                    n_cnt   = '0;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // result valid: set on input transfer, cleared on output transfer
    always_comb begin
        n_out_valid = r_out_valid;
        if (accept) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_valid = r_out_valid;

endmodule

// File: rtl/core/mul_div_register_unit_core.sv
// Channel   Handshake           Payload
// input     i_valid / o_ready   i_kind, i_register_offset, i_write_data
// output    o_valid / i_ready   o_read_data
//
// Reads and most writes register their result at the accept, and the next
// access may be accepted as the result is taken. A write of a nonzero divisor
// then busies the unit for 16 steps of a restoring divider that produces one
// quotient bit per cycle. Multiply forms the 8x8 product as B is written.
// Synchronous active-low reset clears all registers but the read data register to zero.
// A stalled output holds the result and blocks the next input.
module mul_div_register_unit_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_kind,
    input  logic [4:0] i_register_offset,
    input  logic [7:0] i_write_data,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_read_data
);
    import mdru_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    mdru_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (dp_status),
        .o_cmd    (dp_cmd)
    );

    mdru_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .o_status          (dp_status),
        .i_kind            (i_kind),
        .i_register_offset (i_register_offset),
        .i_write_data      (i_write_data),
        .o_read_data       (o_read_data)
    );

    // checks
`include "mul_div_register_unit_core_defines.svh"

    `MDRU_ASSERT_SAME(a_no_ready_in_div, i_clk, i_rst_n, dp_cmd.div_step, !o_ready, "ready during divide")
    `MDRU_ASSERT_NEXT(a_div_start_busy, i_clk, i_rst_n, i_valid && o_ready && dp_status.div_start, dp_cmd.div_step && !o_ready, "divide did not start")
    `MDRU_ASSERT_NEXT(a_accept_gives_result, i_clk, i_rst_n, i_valid && o_ready, o_valid, "no result after transfer")
    `MDRU_ASSERT_SAME(a_no_step_on_accept, i_clk, i_rst_n, dp_cmd.accept, !dp_cmd.div_step, "step during transfer")

endmodule

// File: tb/mul_div_register_unit_core_test.sv
`timescale 1ns / 100ps

module mul_div_register_unit_core_test;
    import mdru_pkg::*;

    localparam int          N_ITEMS      = 1900;
    localparam int          CALM_TAIL    = 200;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 40;
    localparam logic [4:0]  OFS_LOW_END  = 5'h00;
    localparam logic [4:0]  OFS_HIGH_END = 5'h1F;

    // one access of the directed table; rd is checked as typed when fixed is set
    typedef struct {
        logic       kind;
        logic [4:0] ofs;
        logic [7:0] data;
        bit         fixed;
        logic [7:0] rd;
    } t_bus_row;

    localparam int N_ROWS = 25;
    t_bus_row dir_rows [0:N_ROWS-1] = '{
        // everything reads zero after reset
        '{KIND_READ,  OFS_QUOT_L,     8'hFF, 1'b1, 8'h00},
        '{KIND_READ,  OFS_QUOT_H,     8'h00, 1'b1, 8'h00},
        '{KIND_READ,  OFS_PR_L,       8'hA5, 1'b1, 8'h00},
        '{KIND_READ,  OFS_PR_H,       8'h5A, 1'b1, 8'h00},
        // largest product
        '{KIND_WRITE, OFS_MUL_A,      8'hFF, 1'b1, 8'h00},
        '{KIND_WRITE, OFS_MUL_B,      8'hFF, 1'b1, 8'h00},
        '{KIND_READ,  OFS_PR_L,       8'h00, 1'b1, 8'h01},
        '{KIND_READ,  OFS_PR_H,       8'h00, 1'b1, 8'hFE},
        // divide by zero: all-ones quotient, remainder takes the dividend
        '{KIND_WRITE, OFS_DIVIDEND_L, 8'hFF, 1'b1, 8'h00},
        '{KIND_WRITE, OFS_DIVIDEND_H, 8'hFF, 1'b1, 8'h00},
        '{KIND_WRITE, OFS_DIVISOR,    8'h00, 1'b1, 8'h00},
        '{KIND_READ,  OFS_QUOT_L,     8'h00, 1'b1, 8'hFF},
        '{KIND_READ,  OFS_QUOT_H,     8'h00, 1'b1, 8'hFF},
        '{KIND_READ,  OFS_PR_L,       8'h00, 1'b1, 8'hFF},
        // largest dividend over largest divisor
        '{KIND_WRITE, OFS_DIVISOR,    8'hFF, 1'b1, 8'h00},
        '{KIND_READ,  OFS_QUOT_L,     8'h00, 1'b1, 8'h01},
        '{KIND_READ,  OFS_QUOT_H,     8'h00, 1'b1, 8'h01},
        '{KIND_READ,  OFS_PR_H,       8'h00, 1'b1, 8'h00},
        // unmapped writes leave results alone, unmapped reads give zero
        '{KIND_WRITE, OFS_HIGH_END,   8'hAA, 1'b1, 8'h00},
        '{KIND_WRITE, OFS_QUOT_L,     8'h55, 1'b1, 8'h00},
        '{KIND_READ,  OFS_QUOT_L,     8'h00, 1'b1, 8'h01},
        '{KIND_READ,  OFS_LOW_END,    8'h00, 1'b1, 8'h00},
        '{KIND_READ,  OFS_MUL_B,      8'h00, 1'b1, 8'h00},
        // divide by one, checked against the predictor
        '{KIND_WRITE, OFS_DIVISOR,    8'h01, 1'b0, 8'h00},
        '{KIND_READ,  OFS_QUOT_H,     8'h00, 1'b0, 8'h00}
    };

    logic       i_clk;
    logic       i_rst_n           = 1'b0;
    logic       i_valid           = 1'b0;
    logic       o_ready;
    logic       i_kind            = KIND_READ;
    logic [4:0] i_register_offset = '0;
    logic [7:0] i_write_data      = '0;
    logic       o_valid;
    logic       i_ready           = 1'b0;
    logic [7:0] o_read_data;

    // predicted unit registers
    logic [7:0]  mul_a, mul_b, dvs;
    logic [15:0] dvd, quot, prod_rem;

    logic [7:0] read_bytes_q [$];
    int         sent       = 0;
    int         fail_count = 0;
    int         cycles     = 0;
    int         idle_pct   = 25;
    int         stall_pct  = 25;
    bit         calm       = 1'b0;
    bit         out_of_reset = 1'b0;

    mul_div_register_unit_core i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_kind            (i_kind),
        .i_register_offset (i_register_offset),
        .i_write_data      (i_write_data),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_read_data       (o_read_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // apply one access to the predicted registers, return the byte read back
    function automatic logic [7:0] apply_bus_access(input logic kind, input logic [4:0] ofs,
                                                    input logic [7:0] data);
        logic [7:0] rd;
        rd = 8'h00;
        if (kind == KIND_WRITE) begin
            case (ofs)
                OFS_MUL_A: mul_a = data;
                OFS_MUL_B: begin
                    mul_b    = data;
                    prod_rem = {8'h00, mul_a} * {8'h00, mul_b};
                end
                OFS_DIVIDEND_L: dvd[7:0]  = data;
                OFS_DIVIDEND_H: dvd[15:8] = data;
                OFS_DIVISOR: begin
                    dvs = data;
                    if (dvs != 8'h00) begin
                        quot     = dvd / {8'h00, dvs};
                        prod_rem = dvd % {8'h00, dvs};
                    end else begin
                        quot     = QUOT_DIV_ZERO;
                        prod_rem = dvd;
                    end
                end
                default: ;
            endcase
        end else begin
            case (ofs)
                OFS_QUOT_L: rd = quot[7:0];
                OFS_QUOT_H: rd = quot[15:8];
                OFS_PR_L:   rd = prod_rem[7:0];
                OFS_PR_H:   rd = prod_rem[15:8];
                default:    rd = 8'h00;
            endcase
        end
        return rd;
    endfunction

    // operand with the corner values weighted up
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h01;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // drive one access and hold it until the transfer, then record the expected byte
    task automatic drive_access(input logic kind, input logic [4:0] ofs, input logic [7:0] data,
                                input bit fixed = 1'b0, input logic [7:0] rd = 8'h00);
        logic [7:0] pred;
        if (!calm && $urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_kind            <= kind;
        i_register_offset <= ofs;
        i_write_data      <= data;
        do @(posedge i_clk); while (!o_ready);
        pred = apply_bus_access(kind, ofs, data);
        read_bytes_q.push_back(fixed ? rd : pred);
        sent++;
        calm = (sent >= N_ITEMS - CALM_TAIL);
        if (sent % 100 == 0) idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 50);
    endtask

    // receiver: random stall bursts, none near the end
    initial begin
        wait (out_of_reset);
        forever begin
            if (!calm && $urandom_range(0, 99) < stall_pct) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            if ($urandom_range(0, 15) == 0)
                stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 60);
        end
    end

    // compare every output transfer with the oldest expected byte
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (read_bytes_q.size() == 0) begin
                $error("read_data: unexpected transfer, actual %02h", o_read_data);
                fail_count++;
            end else begin
                if (o_read_data !== read_bytes_q[0]) begin
                    $error("read_data: expected %02h, actual %02h", read_bytes_q[0],
                           o_read_data);
                    fail_count++;
                end
                void'(read_bytes_q.pop_front());
            end
        end
    end

    // hard stop
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        int j;
        mul_a    = '0;
        mul_b    = '0;
        dvd      = '0;
        dvs      = '0;
        quot     = '0;
        prod_rem = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n      <= 1'b1;
        out_of_reset = 1'b1;

        // directed table
        for (int r = 0; r < N_ROWS; r++)
            drive_access(dir_rows[r].kind, dir_rows[r].ofs, dir_rows[r].data,
                         dir_rows[r].fixed, dir_rows[r].rd);

        // random sequences: mostly complete multiply and divide runs, some noise
        while (sent < N_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    if ($urandom_range(0, 7) != 0)
                        drive_access(KIND_WRITE, OFS_MUL_A, rand_byte());
                    drive_access(KIND_WRITE, OFS_MUL_B, rand_byte());
                    drive_access(KIND_READ, OFS_PR_L, 8'($urandom_range(0, 255)));
                    drive_access(KIND_READ, OFS_PR_H, 8'($urandom_range(0, 255)));
                    if ($urandom_range(0, 3) == 0)
                        drive_access(KIND_READ, 5'(OFS_QUOT_L + $urandom_range(0, 3)),
                                     8'($urandom_range(0, 255)));
                end
                4, 5, 6, 7: begin
                    if ($urandom_range(0, 7) != 0)
                        drive_access(KIND_WRITE, OFS_DIVIDEND_L, rand_byte());
                    if ($urandom_range(0, 7) != 0)
                        drive_access(KIND_WRITE, OFS_DIVIDEND_H, rand_byte());
                    drive_access(KIND_WRITE, OFS_DIVISOR,
                                 ($urandom_range(0, 9) == 0) ? 8'h00 : rand_byte());
                    for (j = 0; j < 4; j++)
                        if ($urandom_range(0, 4) != 0)
                            drive_access(KIND_READ, 5'(OFS_QUOT_L + j),
                                         8'($urandom_range(0, 255)));
                end
                default: begin
                    repeat ($urandom_range(1, 4))
                        drive_access(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)),
                                     8'($urandom_range(0, 255)));
                end
            endcase
        end
        i_valid <= 1'b0;

        // drain
        while (read_bytes_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
